FILE: rtl/lom_pkg.sv
package lom_pkg;

  localparam int BookDepth = 32;
  localparam int IdxW = $clog2(BookDepth);

  typedef enum logic [2:0] {
    KIND_TRADE    = 3'd0,
    KIND_REJECT   = 3'd1,
    KIND_FILLED   = 3'd2,
    KIND_RESTED   = 3'd3,
    KIND_DROPPED  = 3'd4
  } kind_t;

  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [30:0] quantity;
    logic [31:0] order_id;
    logic [31:0] user_id;
  } order_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] buy_order_id;
    logic [31:0] sell_order_id;
    logic [31:0] buy_user_id;
    logic [31:0] sell_user_id;
    logic [30:0] trade_quantity;
    logic [31:0] trade_price;
    logic [30:0] remaining_quantity;
    logic        last;
  } result_t;

endpackage

FILE: rtl/lom_if.sv
interface lom_order_if (input logic clk);
  import lom_pkg::*;
  logic   valid;
  logic   ready;
  order_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lom_result_if (input logic clk);
  import lom_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/limit_order_matcher.sv
// Limit order matcher, one symbol, price-time priority.
// in_ch (sink) takes one order word: side, price, quantity, order_id, user_id.
// out_ch (source) returns the words of that order: zero or more trades, then
// one status word with last set (rejected, filled, rested or dropped).
// One order is processed at a time; in_ch.ready is high only when idle with
// the output register empty, so a new order waits until the status word of
// the previous one is taken.
// Each fill needs a scan of the opposite side, one slot a cycle through a
// single compare unit. A rejected order loads its status word at the accept
// edge. An order that is not filled searches its own side for a free slot
// to rest in, and is dropped when its own side is full.
// A result word sits in an output register; while out_ch.ready is low the
// sequencer runs on to its next trade or status word and holds there, and
// no word is lost.
// Reset (rst_n low, synchronous) empties both sides of the book (valid bits
// cleared) and sets the arrival counter to zero; the block is ready in the
// first cycle after reset.
module limit_order_matcher (
  input logic        clk,
  input logic        rst_n,
  lom_order_if.sink  in_ch,
  lom_result_if.source out_ch
);
  import lom_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TRADE, S_FREE, S_EMIT
  } state_t;

  // book: index 0 bid, 1 ask
  logic [31:0] bk_price_r [2][BookDepth];
  logic [30:0] bk_qty_r   [2][BookDepth];
  logic [31:0] bk_order_r [2][BookDepth];
  logic [31:0] bk_owner_r [2][BookDepth];
  logic [31:0] bk_arr_r   [2][BookDepth];
  logic [BookDepth-1:0] bk_valid_r [2];

  state_t      state_r;
  order_t      ord_r;
  logic [30:0] qty_r;
  logic [31:0] arrival_r;
  logic [IdxW:0] cnt_r;
  logic        found_r;
  logic [IdxW-1:0] best_r;
  logic [31:0] best_price_r;
  logic [31:0] best_arr_r;
  logic        out_valid_r;
  result_t     out_r;

  logic opp, own;
  logic [IdxW-1:0] ci;
  logic better;
  logic [31:0] cp, ca;
  logic [30:0] bq, tq;
  logic crosses;
  logic out_load;

  assign opp = ~ord_r.side;
  assign own = ord_r.side;
  assign ci  = cnt_r[IdxW-1:0];
  assign cp  = bk_price_r[opp][ci];
  assign ca  = bk_arr_r[opp][ci];
  assign bq  = bk_qty_r[opp][best_r];
  assign tq  = (qty_r < bq) ? qty_r : bq;
  assign crosses = ord_r.side ? (best_price_r >= ord_r.price)
                              : (ord_r.price >= best_price_r);

  always_comb begin
    if (!found_r) better = 1'b1;
    else if (cp != best_price_r) better = ord_r.side ? (cp > best_price_r) : (cp < best_price_r);
    else better = ca < best_arr_r;
  end

  always_comb begin
    case (state_r)
      S_IDLE: out_load = in_ch.valid && in_ch.ready &&
                         (in_ch.data.price == '0 || in_ch.data.quantity == '0);
      S_TRADE, S_EMIT: out_load = !out_valid_r || out_ch.ready;
      default: out_load = 1'b0;
    endcase
  end

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  function automatic result_t status(order_t o, kind_t k, logic [30:0] rem);
    result_t r;
    r = '0;
    r.kind = k;
    if (o.side) begin
      r.sell_order_id = o.order_id;
      r.sell_user_id  = o.user_id;
    end else begin
      r.buy_order_id = o.order_id;
      r.buy_user_id  = o.user_id;
    end
    r.trade_price = o.price;
    r.remaining_quantity = rem;
    r.last = 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bk_valid_r[0] <= '0;
      bk_valid_r[1] <= '0;
      arrival_r   <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            ord_r <= in_ch.data;
            qty_r <= in_ch.data.quantity;
            if (in_ch.data.price == '0 || in_ch.data.quantity == '0) begin
              out_r <= status(in_ch.data, KIND_REJECT, in_ch.data.quantity);
            end else begin
              cnt_r   <= '0;
              found_r <= 1'b0;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnt_r == (IdxW+1)'(BookDepth)) begin
            if (found_r && crosses) state_r <= S_TRADE;
            else begin
              cnt_r   <= '0;
              found_r <= 1'b0;
              state_r <= S_FREE;
            end
          end else begin
            if (bk_valid_r[opp][ci] && better) begin
              found_r      <= 1'b1;
              best_r       <= ci;
              best_price_r <= cp;
              best_arr_r   <= ca;
            end
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_TRADE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r.kind <= KIND_TRADE;
            out_r.buy_order_id  <= ord_r.side ? bk_order_r[opp][best_r] : ord_r.order_id;
            out_r.sell_order_id <= ord_r.side ? ord_r.order_id : bk_order_r[opp][best_r];
            out_r.buy_user_id   <= ord_r.side ? bk_owner_r[opp][best_r] : ord_r.user_id;
            out_r.sell_user_id  <= ord_r.side ? ord_r.user_id : bk_owner_r[opp][best_r];
            out_r.trade_quantity <= tq;
            out_r.trade_price   <= best_price_r;
            out_r.remaining_quantity <= qty_r - tq;
            out_r.last <= 1'b0;
            bk_qty_r[opp][best_r] <= bq - tq;
            if (bq == tq) bk_valid_r[opp][best_r] <= 1'b0;
            qty_r <= qty_r - tq;
            cnt_r <= '0;
            found_r <= 1'b0;
            if (qty_r == tq) state_r <= S_EMIT;
            else state_r <= S_SCAN;
          end
        end
        S_FREE: begin
          if (cnt_r == (IdxW+1)'(BookDepth)) state_r <= S_EMIT;
          else if (!bk_valid_r[own][ci]) begin
            bk_valid_r[own][ci] <= 1'b1;
            bk_price_r[own][ci] <= ord_r.price;
            bk_qty_r[own][ci]   <= qty_r;
            bk_order_r[own][ci] <= ord_r.order_id;
            bk_owner_r[own][ci] <= ord_r.user_id;
            bk_arr_r[own][ci]   <= arrival_r;
            arrival_r <= arrival_r + 1'b1;
            found_r <= 1'b1;
            state_r <= S_EMIT;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            if (qty_r == '0) out_r <= status(ord_r, KIND_FILLED, '0);
            else if (found_r) out_r <= status(ord_r, KIND_RESTED, qty_r);
            else out_r <= status(ord_r, KIND_DROPPED, qty_r);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
